FILE: hw/rtl/jsu_pkg.sv
// Shared types, codes and helper functions of the JSON string unescaper.
`timescale 1ns / 1ps
`default_nettype none
package jsu_pkg;

  localparam int OFFSET_WIDTH_DEF = 16;

  localparam logic [2:0] MODE_PLAIN      = 3'd0;
  localparam logic [2:0] MODE_ESC        = 3'd1;
  localparam logic [2:0] MODE_HEX        = 3'd2;
  localparam logic [2:0] MODE_AFTER_HIGH = 3'd3;
  localparam logic [2:0] MODE_HIGH_U     = 3'd4;
  localparam logic [2:0] MODE_LOW_HEX    = 3'd5;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [3:0] ERR_UNTERMINATED = 4'd0;
  localparam logic [3:0] ERR_CONTROL      = 4'd1;
  localparam logic [3:0] ERR_UNTERM_ESC   = 4'd2;
  localparam logic [3:0] ERR_BAD_ESC      = 4'd3;
  localparam logic [3:0] ERR_TRUNC_U      = 4'd4;
  localparam logic [3:0] ERR_BAD_HEX      = 4'd5;
  localparam logic [3:0] ERR_LONE_HIGH    = 4'd6;
  localparam logic [3:0] ERR_BAD_LOW      = 4'd7;
  localparam logic [3:0] ERR_LONE_LOW     = 4'd8;

  // One input item's results: a count of beats, their kind and code, and the bytes.
  typedef struct packed {
    logic [2:0]            num;
    logic [1:0]            kind;
    logic [3:0]            code;
    logic [3:0][7:0]       data;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic res_t utf8_encode(input logic [20:0] cp);
    res_t r;
    r.kind = KIND_DATA;
    r.code = ERR_UNTERMINATED;
    r.data = '0;
    if (cp < 21'h80) begin
      r.num     = 3'd1;
      r.data[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      r.num     = 3'd2;
      r.data[0] = {3'b110, cp[10:6]};
      r.data[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      r.num     = 3'd3;
      r.data[0] = {4'b1110, cp[15:12]};
      r.data[1] = {2'b10, cp[11:6]};
      r.data[2] = {2'b10, cp[5:0]};
    end else begin
      r.num     = 3'd4;
      r.data[0] = {5'b11110, cp[20:18]};
      r.data[1] = {2'b10, cp[17:12]};
      r.data[2] = {2'b10, cp[11:6]};
      r.data[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/jsu_decode.sv
// Decoder state registers and the single-pass decode of one registered input byte.
`timescale 1ns / 1ps
`default_nettype none
module jsu_decode #(
  parameter int OFFSET_WIDTH = jsu_pkg::OFFSET_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    fire,
  input  wire logic [7:0]              in_byte,
  input  wire logic                    end_of_input,
  output jsu_pkg::res_t                res,
  output logic      [OFFSET_WIDTH-1:0] res_off
);

  localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = {OFFSET_WIDTH{1'b1}};

  logic [2:0]              mode_r, mode_nxt;
  logic [11:0]             acc_r, acc_nxt;
  logic [1:0]              cnt_r, cnt_nxt;
  logic [9:0]              hs_r, hs_nxt;
  logic [OFFSET_WIDTH-1:0] off_r, off_nxt;

  logic                    done;
  jsu_pkg::hex_t           hv;
  logic [15:0]             cp;

  function automatic logic [OFFSET_WIDTH-1:0] back_off(
    input logic [OFFSET_WIDTH-1:0] cur,
    input logic [2:0]              k
  );
    logic [OFFSET_WIDTH-1:0] kk;
    kk = OFFSET_WIDTH'(k);
    if (cur == OFF_MAX) begin
      return OFF_MAX;
    end else if (cur < kk) begin
      return '0;
    end
    return cur - kk;
  endfunction

  assign hv = jsu_pkg::hex_value(in_byte);
  assign cp = {acc_r, hv.val};

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    hs_nxt   = hs_r;
    done     = 1'b0;
    res.num  = 3'd0;
    res.kind = jsu_pkg::KIND_DATA;
    res.code = jsu_pkg::ERR_UNTERMINATED;
    res.data = '0;
    res_off  = '0;
    if (end_of_input) begin
      done     = 1'b1;
      res.num  = 3'd1;
      res.kind = jsu_pkg::KIND_ERROR;
      res_off  = off_r;
      case (mode_r)
        jsu_pkg::MODE_ESC: begin
          res.code = jsu_pkg::ERR_UNTERM_ESC;
        end
        jsu_pkg::MODE_HEX: begin
          res.code = jsu_pkg::ERR_TRUNC_U;
          res_off  = back_off(off_r, {1'b0, cnt_r});
        end
        jsu_pkg::MODE_AFTER_HIGH: begin
          res.code = jsu_pkg::ERR_LONE_HIGH;
        end
        jsu_pkg::MODE_HIGH_U: begin
          res.code = jsu_pkg::ERR_LONE_HIGH;
          res_off  = back_off(off_r, 3'd1);
        end
        jsu_pkg::MODE_LOW_HEX: begin
          res.code = jsu_pkg::ERR_LONE_HIGH;
          res_off  = back_off(off_r, 3'd2 + {1'b0, cnt_r});
        end
        default: begin
          res.code = jsu_pkg::ERR_UNTERMINATED;
        end
      endcase
    end else begin
      case (mode_r)
        jsu_pkg::MODE_ESC: begin
          mode_nxt = jsu_pkg::MODE_PLAIN;
          res.num  = 3'd1;
          case (in_byte)
            8'h22, 8'h5C, 8'h2F: res.data[0] = in_byte;
            8'h62: res.data[0] = 8'h08;
            8'h66: res.data[0] = 8'h0C;
            8'h6E: res.data[0] = 8'h0A;
            8'h72: res.data[0] = 8'h0D;
            8'h74: res.data[0] = 8'h09;
            8'h75: begin
              res.num  = 3'd0;
              mode_nxt = jsu_pkg::MODE_HEX;
              acc_nxt  = '0;
              cnt_nxt  = '0;
            end
            default: begin
              done     = 1'b1;
              res.kind = jsu_pkg::KIND_ERROR;
              res.code = jsu_pkg::ERR_BAD_ESC;
              res_off  = off_r;
            end
          endcase
        end
        jsu_pkg::MODE_HEX, jsu_pkg::MODE_LOW_HEX: begin
          if (!hv.ok) begin
            done     = 1'b1;
            res.num  = 3'd1;
            res.kind = jsu_pkg::KIND_ERROR;
            res.code = jsu_pkg::ERR_BAD_HEX;
            res_off  = off_r;
          end else if (cnt_r != 2'd3) begin
            acc_nxt = {acc_r[7:0], hv.val};
            cnt_nxt = cnt_r + 2'd1;
          end else begin
            acc_nxt = '0;
            cnt_nxt = '0;
            if (mode_r == jsu_pkg::MODE_HEX) begin
              if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
                hs_nxt   = cp[9:0];
                mode_nxt = jsu_pkg::MODE_AFTER_HIGH;
              end else if (cp >= 16'hDC00 && cp <= 16'hDFFF) begin
                done     = 1'b1;
                res.num  = 3'd1;
                res.kind = jsu_pkg::KIND_ERROR;
                res.code = jsu_pkg::ERR_LONE_LOW;
                res_off  = back_off(off_r, 3'd3);
              end else begin
                mode_nxt = jsu_pkg::MODE_PLAIN;
                res      = jsu_pkg::utf8_encode({5'd0, cp});
              end
            end else begin
              if (cp < 16'hDC00 || cp > 16'hDFFF) begin
                done     = 1'b1;
                res.num  = 3'd1;
                res.kind = jsu_pkg::KIND_ERROR;
                res.code = jsu_pkg::ERR_BAD_LOW;
                res_off  = back_off(off_r, 3'd3);
              end else begin
                hs_nxt   = '0;
                mode_nxt = jsu_pkg::MODE_PLAIN;
                res      = jsu_pkg::utf8_encode(21'h10000 + {1'b0, hs_r, cp[9:0]});
              end
            end
          end
        end
        jsu_pkg::MODE_AFTER_HIGH: begin
          if (in_byte == 8'h5C) begin
            mode_nxt = jsu_pkg::MODE_HIGH_U;
          end else begin
            done     = 1'b1;
            res.num  = 3'd1;
            res.kind = jsu_pkg::KIND_ERROR;
            res.code = jsu_pkg::ERR_LONE_HIGH;
            res_off  = off_r;
          end
        end
        jsu_pkg::MODE_HIGH_U: begin
          if (in_byte == 8'h75) begin
            mode_nxt = jsu_pkg::MODE_LOW_HEX;
            acc_nxt  = '0;
            cnt_nxt  = '0;
          end else begin
            done     = 1'b1;
            res.num  = 3'd1;
            res.kind = jsu_pkg::KIND_ERROR;
            res.code = jsu_pkg::ERR_LONE_HIGH;
            res_off  = back_off(off_r, 3'd1);
          end
        end
        default: begin
          mode_nxt = jsu_pkg::MODE_PLAIN;
          if (in_byte == 8'h22) begin
            done     = 1'b1;
            res.num  = 3'd1;
            res.kind = jsu_pkg::KIND_CLOSE;
          end else if (in_byte < 8'h20) begin
            done     = 1'b1;
            res.num  = 3'd1;
            res.kind = jsu_pkg::KIND_ERROR;
            res.code = jsu_pkg::ERR_CONTROL;
            res_off  = off_r;
          end else if (in_byte == 8'h5C) begin
            mode_nxt = jsu_pkg::MODE_ESC;
          end else begin
            res.num     = 3'd1;
            res.data[0] = in_byte;
          end
        end
      endcase
    end

    off_nxt = off_r;
    if (done) begin
      mode_nxt = jsu_pkg::MODE_PLAIN;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      hs_nxt   = '0;
      off_nxt  = '0;
    end else if (off_r != OFF_MAX) begin
      off_nxt = off_r + OFFSET_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jsu_pkg::MODE_PLAIN;
      acc_r  <= '0;
      cnt_r  <= '0;
      hs_r   <= '0;
      off_r  <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      hs_r   <= hs_nxt;
      off_r  <= off_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/jsu_out_buf.sv
// Result register: holds the up to four beats of one item and hands them out in order.
`timescale 1ns / 1ps
`default_nettype none
module jsu_out_buf #(
  parameter int OFFSET_WIDTH = jsu_pkg::OFFSET_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    load,
  input  wire jsu_pkg::res_t           res,
  input  wire logic [OFFSET_WIDTH-1:0] res_off,
  input  wire logic                    pop,
  output logic                         free,
  output logic                         valid,
  output logic      [7:0]              beat_byte,
  output logic      [1:0]              beat_kind,
  output logic      [3:0]              beat_code,
  output logic      [OFFSET_WIDTH-1:0] beat_off,
  output logic                         beat_last
);

  logic [2:0]              cnt_r, cnt_nxt;
  logic [3:0][7:0]         data_r, data_nxt;
  logic [1:0]              kind_r;
  logic [3:0]              code_r;
  logic [OFFSET_WIDTH-1:0] off_r;

  assign valid     = cnt_r != 3'd0;
  assign free      = (cnt_r == 3'd0) || (cnt_r == 3'd1 && pop);
  assign beat_byte = data_r[0];
  assign beat_kind = kind_r;
  assign beat_code = code_r;
  assign beat_off  = off_r;
  assign beat_last = cnt_r == 3'd1;

  always_comb begin
    cnt_nxt  = cnt_r;
    data_nxt = data_r;
    if (pop && valid) begin
      cnt_nxt  = cnt_r - 3'd1;
      data_nxt = {8'd0, data_r[3:1]};
    end
    if (load) begin
      cnt_nxt  = res.num;
      data_nxt = res.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (load) begin
      kind_r <= res.kind;
      code_r <= res.code;
      off_r  <= res_off;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper with UTF-8 output.
// Takes one string-body byte per beat (after the opening quote) and sends decoded UTF-8 bytes,
// a close marker or an error with its code and byte offset. A beat passes an input register,
// one pass of decode logic and a result register before its first output beat.
// Plain bytes and short escapes run at one beat per cycle while out_tready is high; an item whose
// code point leaves as more than one byte holds the input while the result register drains one
// beat per cycle, as out_tready allows. Escape bytes that complete nothing produce no output beat.
`timescale 1ns / 1ps
`default_nettype none
module json_string_unescape_utf8 #(
  parameter int OFFSET_WIDTH = jsu_pkg::OFFSET_WIDTH_DEF,
  localparam int TDATA_W     = ((12 + OFFSET_WIDTH + 7) / 8) * 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,   // in_byte
  input  wire logic               in_tuser,   // end_of_input
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic      [TDATA_W-1:0] out_tdata,  // out_byte, error_code, error_offset, zero fill
  output logic      [1:0]         out_tuser,  // kind
  output logic                    out_tlast   // last
);

  logic                    in_v_r;
  logic [7:0]              in_byte_r;
  logic                    in_eoi_r;
  logic                    advance;
  logic                    buf_free;
  jsu_pkg::res_t           res;
  logic [OFFSET_WIDTH-1:0] res_off;
  logic [7:0]              beat_byte;
  logic [3:0]              beat_code;
  logic [OFFSET_WIDTH-1:0] beat_off;

  assign advance   = in_v_r && buf_free;
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eoi_r  <= in_tuser;
    end
  end

  jsu_decode #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (advance),
    .in_byte      (in_byte_r),
    .end_of_input (in_eoi_r),
    .res          (res),
    .res_off      (res_off)
  );

  jsu_out_buf #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res       (res),
    .res_off   (res_off),
    .pop       (out_tready),
    .free      (buf_free),
    .valid     (out_tvalid),
    .beat_byte (beat_byte),
    .beat_kind (out_tuser),
    .beat_code (beat_code),
    .beat_off  (beat_off),
    .beat_last (out_tlast)
  );

  assign out_tdata = TDATA_W'({beat_off, beat_code, beat_byte});

  a_ctl_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != jsu_pkg::KIND_DATA |-> out_tlast)
    else $error("close or error beat not marked last");

  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == jsu_pkg::KIND_DATA |-> out_tdata[TDATA_W-1:8] == '0)
    else $error("data beat carries error fields");

  a_eoi_gives_error: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_eoi_r |=> out_tvalid && out_tuser == jsu_pkg::KIND_ERROR && out_tlast)
    else $error("end of input did not yield an error beat");

  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !advance |=> in_v_r && $stable(in_byte_r) && $stable(in_eoi_r))
    else $error("pending input item lost");

endmodule
`default_nettype wire

FILE: test/tb_json_string_unescape_utf8.sv
// Testbench for the JSON string unescaper: random and directed string bodies, checked beat by beat.
`timescale 1ns / 1ps
module tb_json_string_unescape_utf8;

  localparam int OFFSET_W = jsu_pkg::OFFSET_WIDTH_DEF;
  localparam int TDATA_W  = ((12 + OFFSET_W + 7) / 8) * 8;
  localparam logic [OFFSET_W-1:0] OFF_MAX = {OFFSET_W{1'b1}};
  localparam logic [7:0] QUOTE  = 8'h22;
  localparam logic [7:0] BSLASH = 8'h5C;
  localparam logic [7:0] CH_U   = 8'h75;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG    = 3000;
  localparam int MAX_REPORTS = 100;

  typedef enum int {
    END_CLOSE, END_CONTROL, END_BAD_ESC, END_BAD_HEX, END_LONE_LOW, END_HIGH_NO_BSLASH,
    END_HIGH_NO_U, END_BAD_LOW, END_EOI_PLAIN, END_EOI_ESC, END_EOI_HEX, END_EOI_AFTER_HIGH,
    END_EOI_HIGH_U, END_EOI_LOW_HEX, END_NOISE
  } ending_t;

  typedef struct {
    logic [7:0]          data;
    logic [1:0]          kind;
    logic [3:0]          code;
    logic [OFFSET_W-1:0] offset;
    logic                last;
  } beat_t;

  class unescape_scoreboard;
    beat_t               pending[$];
    int                  fails;
    logic [2:0]          mode;
    logic [15:0]         acc;
    int                  digits;
    logic [9:0]          high_bits;
    logic [OFFSET_W-1:0] offset;

    function new();
      fails = 0;
      clear();
    endfunction

    function void clear();
      mode      = jsu_pkg::MODE_PLAIN;
      acc       = '0;
      digits    = 0;
      high_bits = '0;
      offset    = '0;
    endfunction

    function void add(logic [7:0] data, logic [1:0] kind, logic [3:0] code,
                      logic [OFFSET_W-1:0] off);
      beat_t b;
      b.data   = data;
      b.kind   = kind;
      b.code   = code;
      b.offset = off;
      b.last   = 1'b0;
      pending  = {pending, b};
    endfunction

    function void add_data(logic [7:0] data);
      add(data, jsu_pkg::KIND_DATA, jsu_pkg::ERR_UNTERMINATED, '0);
    endfunction

    function void add_error(logic [3:0] code, logic [OFFSET_W-1:0] off);
      add(8'h00, jsu_pkg::KIND_ERROR, code, off);
    endfunction

    function logic [OFFSET_W-1:0] back_off(logic [OFFSET_W-1:0] cur, int k);
      if (cur == OFF_MAX) return OFF_MAX;
      if (cur < k) return '0;
      return cur - OFFSET_W'(k);
    endfunction

    function int nibble(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - 8'h30);
      if (c >= "a" && c <= "f") return int'(c - 8'h57);
      if (c >= "A" && c <= "F") return int'(c - 8'h37);
      return -1;
    endfunction

    function void add_utf8(logic [20:0] cp);
      if (cp < 21'h80) begin
        add_data(cp[7:0]);
      end else if (cp < 21'h800) begin
        add_data(8'hC0 | cp[10:6]);
        add_data(8'h80 | cp[5:0]);
      end else if (cp < 21'h10000) begin
        add_data(8'hE0 | cp[15:12]);
        add_data(8'h80 | cp[11:6]);
        add_data(8'h80 | cp[5:0]);
      end else begin
        add_data(8'hF0 | cp[20:18]);
        add_data(8'h80 | cp[17:12]);
        add_data(8'h80 | cp[11:6]);
        add_data(8'h80 | cp[5:0]);
      end
    endfunction

    function void note_input(logic [7:0] c, logic eoi);
      logic [OFFSET_W-1:0] cur;
      int                  first;
      int                  h;
      logic [15:0]         cp;
      logic [20:0]         full;
      int                  last_idx;
      cur   = offset;
      first = pending.size();
      if (eoi) begin
        case (mode)
          jsu_pkg::MODE_ESC:        add_error(jsu_pkg::ERR_UNTERM_ESC, cur);
          jsu_pkg::MODE_HEX:        add_error(jsu_pkg::ERR_TRUNC_U, back_off(cur, digits));
          jsu_pkg::MODE_AFTER_HIGH: add_error(jsu_pkg::ERR_LONE_HIGH, cur);
          jsu_pkg::MODE_HIGH_U:     add_error(jsu_pkg::ERR_LONE_HIGH, back_off(cur, 1));
          jsu_pkg::MODE_LOW_HEX:    add_error(jsu_pkg::ERR_LONE_HIGH, back_off(cur, 2 + digits));
          default:                  add_error(jsu_pkg::ERR_UNTERMINATED, cur);
        endcase
      end else begin
        case (mode)
          jsu_pkg::MODE_ESC: begin
            mode = jsu_pkg::MODE_PLAIN;
            case (c)
              QUOTE, BSLASH, "/": add_data(c);
              "b": add_data(8'h08);
              "f": add_data(8'h0C);
              "n": add_data(8'h0A);
              "r": add_data(8'h0D);
              "t": add_data(8'h09);
              CH_U: begin
                mode   = jsu_pkg::MODE_HEX;
                acc    = '0;
                digits = 0;
              end
              default: add_error(jsu_pkg::ERR_BAD_ESC, cur);
            endcase
          end
          jsu_pkg::MODE_HEX, jsu_pkg::MODE_LOW_HEX: begin
            h = nibble(c);
            if (h < 0) begin
              add_error(jsu_pkg::ERR_BAD_HEX, cur);
            end else if (digits < 3) begin
              acc = {acc[11:0], h[3:0]};
              digits++;
            end else begin
              cp     = {acc[11:0], h[3:0]};
              acc    = '0;
              digits = 0;
              if (mode == jsu_pkg::MODE_HEX) begin
                if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
                  high_bits = cp[9:0];
                  mode      = jsu_pkg::MODE_AFTER_HIGH;
                end else if (cp >= 16'hDC00 && cp <= 16'hDFFF) begin
                  add_error(jsu_pkg::ERR_LONE_LOW, back_off(cur, 3));
                end else begin
                  mode = jsu_pkg::MODE_PLAIN;
                  add_utf8({5'b0, cp});
                end
              end else if (cp < 16'hDC00 || cp > 16'hDFFF) begin
                add_error(jsu_pkg::ERR_BAD_LOW, back_off(cur, 3));
              end else begin
                full      = 21'h10000 + {high_bits, 10'b0} + (cp - 16'hDC00);
                high_bits = '0;
                mode      = jsu_pkg::MODE_PLAIN;
                add_utf8(full);
              end
            end
          end
          jsu_pkg::MODE_AFTER_HIGH: begin
            if (c == BSLASH) mode = jsu_pkg::MODE_HIGH_U;
            else add_error(jsu_pkg::ERR_LONE_HIGH, cur);
          end
          jsu_pkg::MODE_HIGH_U: begin
            if (c == CH_U) begin
              mode   = jsu_pkg::MODE_LOW_HEX;
              acc    = '0;
              digits = 0;
            end else begin
              add_error(jsu_pkg::ERR_LONE_HIGH, back_off(cur, 1));
            end
          end
          default: begin
            mode = jsu_pkg::MODE_PLAIN;
            if (c == QUOTE) add(8'h00, jsu_pkg::KIND_CLOSE, jsu_pkg::ERR_UNTERMINATED, '0);
            else if (c < 8'h20) add_error(jsu_pkg::ERR_CONTROL, cur);
            else if (c == BSLASH) mode = jsu_pkg::MODE_ESC;
            else add_data(c);
          end
        endcase
      end
      if (pending.size() > first) begin
        last_idx = pending.size() - 1;
        pending[last_idx].last = 1'b1;
        if (pending[last_idx].kind != jsu_pkg::KIND_DATA) clear();
        else if (offset != OFF_MAX) offset++;
      end else if (offset != OFF_MAX) begin
        offset++;
      end
    endfunction

    function void check_result(logic [TDATA_W-1:0] tdata, logic [1:0] kind, logic last);
      beat_t              want;
      logic [TDATA_W-1:0] want_bits;
      if (pending.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("%0t: unexpected beat, got tdata %h kind %0d last %b",
                   $time, tdata, kind, last);
        return;
      end
      want                     = pending.pop_front();
      want_bits                = '0;
      want_bits[7:0]           = want.data;
      want_bits[11:8]          = want.code;
      want_bits[12 +: OFFSET_W] = want.offset;
      if (tdata !== want_bits || kind !== want.kind || last !== want.last) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("%0t: beat mismatch, expected tdata %h kind %0d last %b, got tdata %h kind %0d last %b",
                   $time, want_bits, want.kind, want.last, tdata, kind, last);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [7:0]         in_tdata;   // in_byte
  logic               in_tuser;   // end_of_input
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata;  // out_byte, error_code, error_offset, zero fill
  logic [1:0]         out_tuser;  // kind
  logic               out_tlast;  // last

  unescape_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;
  int idle_cycles   = 0;
  bit hold_req      = 1'b0;

  json_string_unescape_utf8 #(.OFFSET_WIDTH(OFFSET_W)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
  end

  initial begin : rx_drive
    int n;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 1'b0;
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= eoi;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_input(b, eoi);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 10) return 8'h30 + nib;
    return ($urandom_range(1) ? 8'h61 : 8'h41) + nib - 8'd10;
  endfunction

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit is_escape(input logic [7:0] c);
    return c == QUOTE || c == BSLASH || c == "/" || c == "b" || c == "f" || c == "n" ||
           c == "r" || c == "t" || c == CH_U;
  endfunction

  function automatic logic [7:0] short_escape(input int i);
    case (i)
      0: return QUOTE;
      1: return BSLASH;
      2: return "/";
      3: return "b";
      4: return "f";
      5: return "n";
      6: return "r";
      default: return "t";
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(8'hFF, 8'h20)); while (c == QUOTE || c == BSLASH);
    return c;
  endfunction

  function automatic logic [15:0] rand_high();
    return 16'hD800 + 16'($urandom_range(10'h3FF));
  endfunction

  function automatic logic [15:0] rand_low();
    return 16'hDC00 + 16'($urandom_range(10'h3FF));
  endfunction

  function automatic logic [15:0] rand_bmp();
    logic [15:0] v;
    case ($urandom_range(3))
      0: v = 16'($urandom_range(16'h7F));
      1: v = 16'($urandom_range(16'h7FF, 16'h80));
      2: begin
        case ($urandom_range(7))
          0: v = 16'h0000;
          1: v = 16'h007F;
          2: v = 16'h0080;
          3: v = 16'h07FF;
          4: v = 16'h0800;
          5: v = 16'hD7FF;
          6: v = 16'hE000;
          default: v = 16'hFFFF;
        endcase
      end
      default: v = 16'($urandom_range(16'hFFFF));
    endcase
    if (v >= 16'hD800 && v <= 16'hDFFF) v = v ^ 16'h4000;
    return v;
  endfunction

  function automatic logic [15:0] rand_not_low();
    logic [15:0] v;
    do v = 16'($urandom_range(16'hFFFF)); while (v >= 16'hDC00 && v <= 16'hDFFF);
    return v;
  endfunction

  task automatic send_eoi();
    send_beat(rand_byte(), 1'b1);
  endtask

  task automatic send_digits(input int n);
    repeat (n) send_beat(hex_char(4'($urandom_range(15))), 1'b0);
  endtask

  task automatic send_u_head();
    send_beat(BSLASH, 1'b0);
    send_beat(CH_U, 1'b0);
  endtask

  task automatic send_u(input logic [15:0] v);
    int k;
    send_u_head();
    for (k = 3; k >= 0; k--) send_beat(hex_char(v[4*k +: 4]), 1'b0);
  endtask

  task automatic send_piece();
    case ($urandom_range(5))
      0, 1: send_beat(rand_plain(), 1'b0);
      2: begin
        send_beat(BSLASH, 1'b0);
        send_beat(short_escape($urandom_range(7)), 1'b0);
      end
      3, 4: send_u(rand_bmp());
      default: begin
        send_u(rand_high());
        send_u(rand_low());
      end
    endcase
  endtask

  task automatic send_string();
    ending_t    ending;
    logic [7:0] c;
    int         n;
    repeat ($urandom_range(6)) send_piece();
    ending = ending_t'($urandom_range(END_NOISE));
    if ($urandom_range(1)) ending = END_CLOSE;
    case (ending)
      END_CLOSE:   send_beat(QUOTE, 1'b0);
      END_CONTROL: send_beat(8'($urandom_range(8'h1F)), 1'b0);
      END_BAD_ESC: begin
        send_beat(BSLASH, 1'b0);
        do c = rand_byte(); while (is_escape(c));
        send_beat(c, 1'b0);
      end
      END_BAD_HEX: begin
        if ($urandom_range(1)) send_u(rand_high());
        send_u_head();
        send_digits($urandom_range(3));
        do c = rand_byte(); while (is_hex(c));
        send_beat(c, 1'b0);
      end
      END_LONE_LOW: send_u(rand_low());
      END_HIGH_NO_BSLASH: begin
        send_u(rand_high());
        do c = rand_byte(); while (c == BSLASH);
        send_beat(c, 1'b0);
      end
      END_HIGH_NO_U: begin
        send_u(rand_high());
        send_beat(BSLASH, 1'b0);
        do c = rand_byte(); while (c == CH_U);
        send_beat(c, 1'b0);
      end
      END_BAD_LOW: begin
        send_u(rand_high());
        send_u(rand_not_low());
      end
      END_EOI_PLAIN: send_eoi();
      END_EOI_ESC: begin
        send_beat(BSLASH, 1'b0);
        send_eoi();
      end
      END_EOI_HEX: begin
        send_u_head();
        send_digits($urandom_range(3));
        send_eoi();
      end
      END_EOI_AFTER_HIGH: begin
        send_u(rand_high());
        send_eoi();
      end
      END_EOI_HIGH_U: begin
        send_u(rand_high());
        send_beat(BSLASH, 1'b0);
        send_eoi();
      end
      END_EOI_LOW_HEX: begin
        send_u(rand_high());
        send_u_head();
        send_digits($urandom_range(3));
        send_eoi();
      end
      default: begin
        n = $urandom_range(6, 1);
        repeat (n) send_beat(rand_byte(), $urandom_range(7) == 0);
      end
    endcase
  endtask

  initial begin
    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tuser  = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 29;
    recv_idle_pct = 73;
    send_beat(8'h20, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(BSLASH, 1'b0);
    send_beat(QUOTE, 1'b0);
    send_u(16'h00E9);
    send_beat(QUOTE, 1'b0);
    send_u(16'hD83D);
    send_u(16'hDE00);
    send_beat(8'h1F, 1'b0);
    send_beat(8'h00, 1'b1);
    while (items_sent < 140) send_string();

    // stall the receiver while strings are still sent, then let everything drain
    hold_req = 1'b1;
    while (hold_req) send_string();
    wait_drained();

    send_idle_pct = 73;
    recv_idle_pct = 29;
    while (items_sent < 280) send_string();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (items_sent < 410) send_string();

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
